[rtl/ddbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddbt_pkg
// Shared types and constants of the block allocation table translator.
// ----------------------------------------------------------------------------
package ddbt_pkg;

  localparam int TableEntries  = 4096;
  localparam int IdxW          = $clog2(TableEntries);
  localparam int MaxSpanBlocks = 16;
  localparam int SpanW         = $clog2(MaxSpanBlocks);

  localparam logic [31:0] Unalloc = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_FETCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_SPAN    = 3'd3,
    ST_BADENT  = 3'd4,
    ST_TOOBIG  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_BS_LOG2  = 3'd0,
    CFG_TBL_OFF  = 3'd1,
    CFG_FOOTER   = 3'd2,
    CFG_DISK     = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] byte_offset;
    logic [31:0] byte_count;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] physical_offset;
    logic [28:0] segment_length;
    logic        zero_fill;
    logic        last;
    logic [31:0] table_word;
    logic [31:0] new_footer_sector;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/ddbt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddbt_in_if / ddbt_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface ddbt_in_if import ddbt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ddbt_out_if import ddbt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/dynamic_disk_block_table_translator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_disk_block_table_translator
// Translates virtual byte accesses through the allocation table of a dynamic
// disk image into per-block image segments; also loads and reads entries.
// ----------------------------------------------------------------------------
// Sequence: a check error is offered from S_OUT after S_CHECK, a load/readback
//   beat after the S_ENTRY write or read and its data; an access scans its N
//   blocks (one table read each), a write then allocates (a read and write-back
//   per block), then each segment takes a table read, its data and its output beat.
// Throughput: one item at a time, as input is taken only in S_IDLE, after the
//   last beat of the previous item has been taken.
// Reset: synchronous, clears control state and restores register defaults;
//   table contents are undefined until loaded.
module dynamic_disk_block_table_translator
  import ddbt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  ddbt_in_if.sink          in_ch,
  ddbt_out_if.source       out_ch
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,  // zero-length, bounds and span checks on the latched item
    S_SCAN  = 7'b0000100,  // read each entry, validate, count unallocated
    S_ALLOC = 7'b0001000,  // write assigned sectors back
    S_EMIT  = 7'b0010000,  // read entry, then send its segment
    S_ENTRY = 7'b0100000,  // load/readback data path
    S_OUT   = 7'b1000000   // waiting for the output beat to be taken
  } state_t;

  state_t state;

  // configuration; the footer register only seeds next_free
  logic [4:0]  bs_log2;
  logic [47:0] tbl_off;
  logic [47:0] disk_size;
  logic [12:0] tbl_limit;
  logic [31:0] next_free;

  // table memory, one port, registered read
  logic [31:0] mem [TableEntries];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [IdxW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // latched item
  in_item_t    item;
  logic [4:0]  lg;
  logic [47:0] end_b;
  logic [IdxW-1:0] bfirst, blast, blk;
  logic        rd_pend;   // rd_data holds entry for blk
  logic [SpanW:0] need;
  logic [31:0] cur;
  out_item_t   obuf;
  logic        emit_done;

  // clamped block size and derived sizes
  logic [4:0]  lg_c;
  logic [47:0] bs_mask;
  logic [47:0] bmp;
  logic [31:0] blk_sectors;
  always_comb begin
    lg_c = (bs_log2 < 5'd12) ? 5'd12 : ((bs_log2 > 5'd28) ? 5'd28 : bs_log2);
    bs_mask = (48'd1 << lg) - 48'd1;
    // bitmap bytes = bs/4096 rounded up to 512; lg<=21 gives 512
    bmp = (lg <= 5'd21) ? 48'd512 : (48'd1 << (lg - 5'd12));
    blk_sectors = 32'((48'd1 << lg) + bmp) >> 9;
  end

  // check-stage values
  logic [48:0] end_full;
  logic [47:0] bl_full, bf_full;
  logic [2:0]  chk_st;
  logic        chk_err;
  always_comb begin
    end_full = {1'b0, item.byte_offset} + {17'd0, item.byte_count} - 49'd1;
    bl_full  = end_full[47:0] >> lg;
    bf_full  = item.byte_offset >> lg;
    chk_err  = 1'b1;
    chk_st   = ST_OK;
    if (item.byte_count == 32'd0) begin
      chk_st = ST_ZERO;
    end else if (end_full[48] || end_full[47:0] >= disk_size
                 || bl_full >= {35'd0, tbl_limit}
                 || bl_full >= 48'(TableEntries)) begin
      chk_st = ST_BOUNDS;
    end else if (bl_full - bf_full >= 48'(MaxSpanBlocks)) begin
      chk_st = ST_SPAN;
    end else begin
      chk_err = 1'b0;
    end
  end

  logic [47:0] ent_byte;
  assign ent_byte = {7'd0, rd_data, 9'd0};
  logic [47:0] footer_byte;
  assign footer_byte = {7'd0, next_free, 9'd0};

  // allocated entry outside the data area
  logic bad_ent;
  assign bad_ent = (rd_data != Unalloc) && (ent_byte >= footer_byte || ent_byte <= tbl_off);

  logic [36:0] newf;
  assign newf = {5'd0, next_free} + 37'(need) * {5'd0, blk_sectors};

  // segment of block blk
  logic [47:0] seg_s, seg_t;
  out_item_t   seg_beat;
  always_comb begin
    seg_s = (blk == bfirst) ? (item.byte_offset & bs_mask) : 48'd0;
    seg_t = (blk == blast) ? (end_b & bs_mask) : bs_mask;
    seg_beat = '0;
    seg_beat.status = ST_OK;
    seg_beat.segment_length = 29'(seg_t - seg_s + 48'd1);
    seg_beat.last = (blk == blast);
    seg_beat.new_footer_sector = next_free;
    if (rd_data == Unalloc) begin
      seg_beat.zero_fill = 1'b1;
    end else begin
      seg_beat.physical_offset = ent_byte + bmp + seg_s;
    end
  end

  function automatic out_item_t err_beat(input logic [2:0] st, input logic [31:0] nf);
    out_item_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    o.new_footer_sector = nf;
    return o;
  endfunction

  function automatic out_item_t word_beat(input logic [31:0] w, input logic [31:0] nf);
    out_item_t o;
    o = '0;
    o.status = ST_OK;
    o.last = 1'b1;
    o.table_word = w;
    o.new_footer_sector = nf;
    return o;
  endfunction

  always_comb begin
    mem_we = 1'b0;
    mem_addr = blk;
    mem_wdata = cur;
    if (state == S_ENTRY) begin
      mem_addr = item.entry_index[IdxW-1:0];
    end else if (state == S_ALLOC && rd_pend && rd_data == Unalloc) begin
      mem_we = 1'b1;
    end
    if (state == S_ENTRY && !rd_pend && item.operation == OP_LOAD) begin
      mem_we = 1'b1;
      mem_wdata = item.entry_value;
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bs_log2 <= 5'd21;
      tbl_off <= 48'd1536;
      disk_size <= '0;
      tbl_limit <= '0;
      next_free <= '0;
      rd_pend <= 1'b0;
      emit_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BS_LOG2: bs_log2 <= cfg_data[4:0];
          CFG_TBL_OFF: tbl_off <= cfg_data;
          CFG_FOOTER:  next_free <= cfg_data[31:0];
          CFG_DISK:    disk_size <= cfg_data;
          CFG_LIMIT:   tbl_limit <= cfg_data[12:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            item <= in_ch.data;
            lg <= lg_c;
            rd_pend <= 1'b0;
            state <= (in_ch.data.operation >= OP_LOAD) ? S_ENTRY : S_CHECK;
          end
        end
        S_ENTRY: begin
          // rd_pend clear: write or read issued; rd_pend set: data back
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            obuf <= word_beat((item.operation == OP_LOAD) ? item.entry_value : rd_data,
                              next_free);
            emit_done <= 1'b1;
            state <= S_OUT;
          end
        end
        S_CHECK: begin
          end_b <= end_full[47:0];
          bfirst <= bf_full[IdxW-1:0];
          blast <= bl_full[IdxW-1:0];
          blk <= bf_full[IdxW-1:0];
          need <= '0;
          rd_pend <= 1'b0;
          obuf <= err_beat(chk_st, next_free);
          emit_done <= chk_err;
          state <= chk_err ? S_OUT : S_SCAN;
        end
        S_SCAN: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (bad_ent) begin
              obuf <= err_beat(ST_BADENT, next_free);
              emit_done <= 1'b1;
              state <= S_OUT;
            end else begin
              if (rd_data == Unalloc) begin
                need <= need + 1'b1;
              end
              if (blk == blast) begin
                blk <= bfirst;
                cur <= next_free;
                state <= (item.operation == OP_WRITE
                          && (need != 0 || rd_data == Unalloc)) ? S_ALLOC : S_EMIT;
              end else begin
                blk <= blk + 1'b1;
              end
            end
          end
        end
        S_ALLOC: begin
          if (!rd_pend && newf > 37'h0_FFFF_FFFF) begin
            obuf <= err_beat(ST_TOOBIG, next_free);
            emit_done <= 1'b1;
            state <= S_OUT;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (rd_data == Unalloc) begin
              cur <= cur + blk_sectors;
            end
            if (blk == blast) begin
              blk <= bfirst;
              next_free <= newf[31:0];
              state <= S_EMIT;
            end else begin
              blk <= blk + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            obuf <= seg_beat;
            emit_done <= (blk == blast);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (emit_done) begin
              state <= S_IDLE;
            end else begin
              blk <= blk + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ddbt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddbt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
module ddbt_checker
  import ddbt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // one item at a time: no input taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready during output");

  // error beats are always final and carry no segment
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.last
      && out_data.segment_length == 29'd0) else $error("bad error beat");

  // zero-fill segments carry no offset
  a_zf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_fill |-> out_data.physical_offset == 48'd0)
    else $error("zero fill with offset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output dropped");

endmodule

bind dynamic_disk_block_table_translator ddbt_checker u_ddbt_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
